// File: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Default sizes
    localparam int ValueBitsDef = 32;
    localparam int MaxCharsDef  = 32;

    // Field widths fixed by the stream format
    localparam int FuncW   = 2;
    localparam int MinLenW = 6;
    localparam int CharW   = 8;
    localparam int DigitW  = 4;

    // Character codes
    localparam logic [CharW-1:0] ChrZero    = 8'h30;
    localparam logic [CharW-1:0] ChrHexBase = 8'h37;   // 'A' - 10
    localparam logic [CharW-1:0] ChrMinus   = 8'h2D;
    localparam logic [CharW-1:0] ChrNine    = 8'h39;
    localparam logic [CharW-1:0] ChrUpperA  = 8'h41;
    localparam logic [CharW-1:0] ChrUpperF  = 8'h46;

    // Format selector codes
    localparam logic [FuncW-1:0] FmtSignedDec   = 2'd0;
    localparam logic [FuncW-1:0] FmtUnsignedDec = 2'd1;
    localparam logic [FuncW-1:0] FmtSignedHex   = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_SIGN,
        S_PAD,
        S_DIGIT
    } t_state;

    // Control fanned out to every digit cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic shift;   // take one magnitude bit in at the bottom
        logic dec;     // decimal correction (add 3 at five or more)
        logic up;      // move digits one place towards the top cell
    } t_chain_ctl;

    // Decimal digits needed for an unsigned number of the given width
    // (ceil(bits * log10(2)), worked out at elaboration)
    function automatic int dec_digits(input int bits);
        return (bits * 30103 + 99999) / 100000;
    endfunction

    // ASCII code of one digit, decimal or hexadecimal
    function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
        logic [CharW-1:0] ext;
        ext = {{(CharW-DigitW){1'b0}}, d};
        return (d < 4'd10) ? (ChrZero + ext) : (ChrHexBase + ext);
    endfunction

endpackage

// File: rtl/itoa_cell.sv
// ----------------------------------------------------------------------------
// itoa_cell
// One digit cell: shift-and-correct step for binary to BCD, plain nibble
// shift for hexadecimal, and upward digit move for emission.
// ----------------------------------------------------------------------------
module itoa_cell (
    input  logic                          i_clk,
    input  itoa_pkg::t_chain_ctl          i_ctl,
    input  logic                          i_bit,          // carry from cell below
    input  logic [itoa_pkg::DigitW-1:0]   i_digit_below,
    output logic                          o_carry,        // carry to cell above
    output logic [itoa_pkg::DigitW-1:0]   o_digit
);

    logic [itoa_pkg::DigitW-1:0] r_digit;
    logic [itoa_pkg::DigitW-1:0] w_adj;

    // Add-3 correction before the shift in decimal mode
    always_comb begin
        if (i_ctl.dec && (r_digit >= 4'd5)) begin
            w_adj = r_digit + 4'd3;
        end else begin
            w_adj = r_digit;
        end
    end

    assign o_carry = w_adj[itoa_pkg::DigitW-1];
    assign o_digit = r_digit;

    // Digit register
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= '0;
        end else if (i_ctl.shift) begin
            r_digit <= {w_adj[itoa_pkg::DigitW-2:0], i_bit};
        end else if (i_ctl.up) begin
            r_digit <= i_digit_below;
        end
    end

endmodule

// File: rtl/itoa_digit_chain.sv
// ----------------------------------------------------------------------------
// itoa_digit_chain
// Row of digit cells, least significant at the bottom. Magnitude bits enter
// the bottom cell; digits leave from the top cell.
// ----------------------------------------------------------------------------
module itoa_digit_chain #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                          i_clk,
    input  itoa_pkg::t_chain_ctl          i_ctl,
    input  logic                          i_bit,
    output logic [itoa_pkg::DigitW-1:0]   o_top_digit
);

    logic [itoa_pkg::DigitW-1:0] w_digit [NUM_DIGITS];
    logic                        w_carry [NUM_DIGITS-1];

    // Cells chained by carry (upwards) and by digit (upwards on emission)
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        logic                        w_in_bit;
        logic [itoa_pkg::DigitW-1:0] w_below;

        if (g == 0) begin : g_bottom
            assign w_in_bit = i_bit;
            assign w_below  = '0;
        end else begin : g_upper
            assign w_in_bit = w_carry[g-1];
            assign w_below  = w_digit[g-1];
        end

        if (g == NUM_DIGITS - 1) begin : g_top
            itoa_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (i_ctl),
                .i_bit         (w_in_bit),
                .i_digit_below (w_below),
                .o_carry       (),
                .o_digit       (w_digit[g])
            );
        end else begin : g_mid
            itoa_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (i_ctl),
                .i_bit         (w_in_bit),
                .i_digit_below (w_below),
                .o_carry       (w_carry[g]),
                .o_digit       (w_digit[g])
            );
        end
    end

    assign o_top_digit = w_digit[NUM_DIGITS-1];

endmodule

// File: rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one integer as ASCII characters, most significant first, with a
// sign and zero padding up to a minimum length.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake               | Payload
//  --------+-----+-------------------------+------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready | tuser: func; tdata: value, min_len
//  m       | out | o_m_tvalid / i_m_tready | tdata: char_code; tlast: last
//
//  An item goes through bit-serial conversion in the cell row; then leading
//  zeros are stripped (up to NUM_DIGITS-1) and the padding is fixed, the
//  characters are emitted one by one, and the sequencer returns to idle to
//  take the next item.
//  Reset clears the sequencer and the output register; no clearing pass.
//  A stall on the output holds the character in the output register and
//  freezes the emitting states; a new item is taken once the last character
//  is in the output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core #(
    parameter int VALUE_BITS = itoa_pkg::ValueBitsDef,
    parameter int MAX_CHARS  = itoa_pkg::MaxCharsDef,
    localparam int InDataW   = ((VALUE_BITS + itoa_pkg::MinLenW + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [InDataW-1:0]            i_s_tdata,   // value, min_len, zero fill
    input  logic [itoa_pkg::FuncW-1:0]    i_s_tuser,   // func
    // output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [itoa_pkg::CharW-1:0]    o_m_tdata,   // char_code
    output logic                          o_m_tlast    // last
);

    localparam int NumDigits = itoa_pkg::dec_digits(VALUE_BITS);
    localparam int CntW      = $clog2(VALUE_BITS);
    localparam int NdigW     = $clog2(NumDigits + 1);
    localparam int LenW      = $clog2(MAX_CHARS + 1);
    localparam int SumW      = ((LenW > NdigW) ? LenW : NdigW) + 1;

    // Input fields
    logic [VALUE_BITS-1:0]          w_value;
    logic [itoa_pkg::MinLenW-1:0]   w_min_len;
    logic                           w_signed;
    logic                           w_neg;
    logic [LenW-1:0]                w_len_sat;
    logic                           w_accept;

    assign w_value   = i_s_tdata[VALUE_BITS-1:0];
    assign w_min_len = i_s_tdata[VALUE_BITS +: itoa_pkg::MinLenW];
    assign w_signed  = (i_s_tuser != itoa_pkg::FmtUnsignedDec);
    assign w_neg     = w_signed && w_value[VALUE_BITS-1];
    assign w_len_sat = (32'(w_min_len) > 32'(MAX_CHARS)) ? LenW'(MAX_CHARS)
                                                         : LenW'(w_min_len);

    // Registers
    itoa_pkg::t_state               r_state, n_state;
    logic [VALUE_BITS-1:0]          r_mag;
    logic                           r_neg;
    logic                           r_dec;
    logic [LenW-1:0]                r_len;
    logic [CntW-1:0]                r_cnt;
    logic [NdigW-1:0]               r_ndig;
    logic [LenW-1:0]                r_pad;
    logic                           r_ov;
    logic [itoa_pkg::CharW-1:0]     r_char;
    logic                           r_last;

    // Chain and emission control
    itoa_pkg::t_chain_ctl           w_ctl;
    logic [itoa_pkg::DigitW-1:0]    w_top;
    logic                           w_adv;
    logic                           w_strip;
    logic                           w_emit;
    logic [itoa_pkg::CharW-1:0]     w_char;
    logic                           w_last;
    logic [SumW-1:0]                w_need;
    logic [LenW-1:0]                w_pad;

    assign o_s_tready = (r_state == itoa_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_adv      = !r_ov || i_m_tready;
    assign w_strip    = (w_top == '0) && (r_ndig > NdigW'(1));

    // Padding once the digit count is known
    assign w_need = SumW'(r_ndig) + SumW'(r_neg);
    assign w_pad  = (SumW'(r_len) > w_need) ? LenW'(SumW'(r_len) - w_need) : '0;

    itoa_digit_chain #(
        .NUM_DIGITS (NumDigits)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_bit       (r_mag[VALUE_BITS-1]),
        .o_top_digit (w_top)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            itoa_pkg::S_IDLE: begin
                if (w_accept) n_state = itoa_pkg::S_CONV;
            end
            itoa_pkg::S_CONV: begin
                if (r_cnt == '0) n_state = itoa_pkg::S_NORM;
            end
            itoa_pkg::S_NORM: begin
                if (!w_strip) begin
                    if (r_neg)             n_state = itoa_pkg::S_SIGN;
                    else if (w_pad != '0)  n_state = itoa_pkg::S_PAD;
                    else                   n_state = itoa_pkg::S_DIGIT;
                end
            end
            itoa_pkg::S_SIGN: begin
                if (w_adv) begin
                    n_state = (r_pad != '0) ? itoa_pkg::S_PAD : itoa_pkg::S_DIGIT;
                end
            end
            itoa_pkg::S_PAD: begin
                if (w_adv && (r_pad == LenW'(1))) n_state = itoa_pkg::S_DIGIT;
            end
            itoa_pkg::S_DIGIT: begin
                if (w_adv && (r_ndig == NdigW'(1))) n_state = itoa_pkg::S_IDLE;
            end
            default: n_state = itoa_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        w_ctl.clear = w_accept;
        w_ctl.shift = (r_state == itoa_pkg::S_CONV);
        w_ctl.dec   = r_dec;
        w_ctl.up    = 1'b0;
        w_emit      = 1'b0;
        w_char      = itoa_pkg::ChrZero;
        w_last      = 1'b0;
        case (r_state)
            itoa_pkg::S_NORM: begin
                w_ctl.up = w_strip;
            end
            itoa_pkg::S_SIGN: begin
                w_emit = w_adv;
                w_char = itoa_pkg::ChrMinus;
            end
            itoa_pkg::S_PAD: begin
                w_emit = w_adv;
                w_char = itoa_pkg::ChrZero;
            end
            itoa_pkg::S_DIGIT: begin
                w_emit   = w_adv;
                w_ctl.up = w_adv;
                w_char   = itoa_pkg::digit_char(w_top);
                w_last   = (r_ndig == NdigW'(1));
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item context and counters
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag <= w_neg ? (~w_value + VALUE_BITS'(1)) : w_value;
            r_neg <= w_neg;
            r_dec <= !i_s_tuser[1];
            r_len <= w_len_sat;
            r_cnt <= CntW'(VALUE_BITS - 1);
        end else if (r_state == itoa_pkg::S_CONV) begin
            r_mag <= {r_mag[VALUE_BITS-2:0], 1'b0};
            r_cnt <= r_cnt - CntW'(1);
        end

        if (r_state == itoa_pkg::S_CONV) begin
            r_ndig <= NdigW'(NumDigits);
        end else if (w_ctl.up) begin
            r_ndig <= r_ndig - NdigW'(1);
        end

        if (r_state == itoa_pkg::S_NORM) begin
            r_pad <= w_pad;
        end else if (w_emit && (r_state == itoa_pkg::S_PAD)) begin
            r_pad <= r_pad - LenW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_char;
    assign o_m_tlast  = r_last;

endmodule

// File: rtl/itoa_checker.sv
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks for the integer-to-ASCII formatter, bound to the core.
// ----------------------------------------------------------------------------
module itoa_checker #(
    parameter int VALUE_BITS = itoa_pkg::ValueBitsDef,
    parameter int MAX_CHARS  = itoa_pkg::MaxCharsDef,
    localparam int InDataW   = ((VALUE_BITS + itoa_pkg::MinLenW + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          o_s_tready,
    input  logic [InDataW-1:0]            i_s_tdata,   // value, min_len, zero fill
    input  logic [itoa_pkg::FuncW-1:0]    i_s_tuser,   // func
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [itoa_pkg::CharW-1:0]    o_m_tdata,   // char_code
    input  logic                          o_m_tlast    // last
);

    logic w_unused;
    assign w_unused = ^{i_s_tvalid, o_s_tready, i_s_tdata, i_s_tuser, MAX_CHARS[0]};

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // Only digits, A-F or minus leave the block
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            (o_m_tdata == itoa_pkg::ChrMinus) ||
            ((o_m_tdata >= itoa_pkg::ChrZero) && (o_m_tdata <= itoa_pkg::ChrNine)) ||
            ((o_m_tdata >= itoa_pkg::ChrUpperA) && (o_m_tdata <= itoa_pkg::ChrUpperF)))
        else $error("illegal character code");

    // A stalled transaction is held
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

endmodule

bind integer_to_ascii_formatter_core itoa_checker #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_CHARS  (MAX_CHARS)
) u_itoa_checker (.*);
